// ===== design/rld_pkg.sv =====
// Shared types and constants for the range limits descriptor encoder.
package rld_pkg;

	localparam logic [9:0]  RATE_LIMIT  = 10'd510;
	localparam logic [9:0]  RATE_OFFSET = 10'd255;
	localparam logic [11:0] CLOCK_LOW   = 12'd10;
	localparam logic [11:0] CLOCK_LIMIT = 12'd2550;

	// floor(x / 10) = (x * 3277) >> 15, exact for every 12-bit x
	localparam logic [11:0] DIV10_MUL   = 12'd3277;
	localparam int          DIV10_SHIFT = 15;

	localparam logic [7:0] RANGE_TAG = 8'hFD;
	localparam logic [7:0] PAD_LF    = 8'h0A;
	localparam logic [7:0] PAD_SPACE = 8'h20;

	localparam logic [3:0] FLAG_H_BOTH = 4'hC;
	localparam logic [3:0] FLAG_H_MAX  = 4'h8;
	localparam logic [3:0] FLAG_V_BOTH = 4'h3;
	localparam logic [3:0] FLAG_V_MAX  = 4'h2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MIN_H     = 3'd1;
	localparam logic [2:0] ERR_MAX_H     = 3'd2;
	localparam logic [2:0] ERR_MIN_V     = 3'd3;
	localparam logic [2:0] ERR_MAX_V     = 3'd4;
	localparam logic [2:0] ERR_CLK_RANGE = 3'd5;
	localparam logic [2:0] ERR_CLK_MULT  = 3'd6;

	// descriptor byte positions
	localparam logic [4:0] IDX_TAG   = 5'd3;
	localparam logic [4:0] IDX_FLAGS = 5'd4;
	localparam logic [4:0] IDX_VMIN  = 5'd5;
	localparam logic [4:0] IDX_VMAX  = 5'd6;
	localparam logic [4:0] IDX_HMIN  = 5'd7;
	localparam logic [4:0] IDX_HMAX  = 5'd8;
	localparam logic [4:0] IDX_CLK   = 5'd9;
	localparam logic [4:0] IDX_TSUP  = 5'd10;
	localparam logic [4:0] IDX_LF    = 5'd11;
	localparam logic [4:0] IDX_LAST  = 5'd17;

	typedef struct packed {
		logic [9:0]  min_vertical_hz;
		logic [9:0]  max_vertical_hz;
		logic [9:0]  min_horizontal_khz;
		logic [9:0]  max_horizontal_khz;
		logic [11:0] max_pixel_clock_mhz;
		logic [7:0]  timing_support;
	} req_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [4:0] byte_index;
		logic       last;
		logic [2:0] error_code;
	} res_t;

	typedef struct packed {
		logic [2:0] err;
		logic [3:0] flags;
		logic [7:0] vmin;
		logic [7:0] vmax;
		logic [7:0] hmin;
		logic [7:0] hmax;
		logic [7:0] clk_div;
		logic [7:0] tsup;
	} desc_t;

endpackage

// ===== design/rld_encode.sv =====
// Range checks, rate offsets and clock scaling for one request.
module rld_encode
	import rld_pkg::*;
(
	input  req_t  req,
	output desc_t desc
);

	logic        hmin_ok, hmax_ok, vmin_ok, vmax_ok, clk_ok, clk_mult;
	logic [23:0] prod;
	logic [8:0]  quot;
	logic [11:0] quot10;
	logic        h_both, v_both;
	logic [9:0]  hmin_o, hmax_o, vmin_o, vmax_o;

	assign hmin_ok = (req.min_horizontal_khz != 10'd0) && (req.min_horizontal_khz <= RATE_LIMIT);
	assign hmax_ok = (req.max_horizontal_khz != 10'd0) && (req.max_horizontal_khz <= RATE_LIMIT);
	assign vmin_ok = (req.min_vertical_hz != 10'd0) && (req.min_vertical_hz <= RATE_LIMIT);
	assign vmax_ok = (req.max_vertical_hz != 10'd0) && (req.max_vertical_hz <= RATE_LIMIT);
	assign clk_ok  = (req.max_pixel_clock_mhz >= CLOCK_LOW)
		&& (req.max_pixel_clock_mhz <= CLOCK_LIMIT);

	assign prod     = req.max_pixel_clock_mhz * DIV10_MUL;
	assign quot     = prod[DIV10_SHIFT +: 9];
	assign quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign clk_mult = (quot10 == req.max_pixel_clock_mhz);

	assign h_both = (req.min_horizontal_khz > RATE_OFFSET) && (req.max_horizontal_khz > RATE_OFFSET);
	assign v_both = (req.min_vertical_hz > RATE_OFFSET) && (req.max_vertical_hz > RATE_OFFSET);

	always_comb begin
		hmin_o = h_both ? req.min_horizontal_khz - RATE_OFFSET : req.min_horizontal_khz;
		hmax_o = (req.max_horizontal_khz > RATE_OFFSET)
			? req.max_horizontal_khz - RATE_OFFSET : req.max_horizontal_khz;
		vmin_o = v_both ? req.min_vertical_hz - RATE_OFFSET : req.min_vertical_hz;
		vmax_o = (req.max_vertical_hz > RATE_OFFSET)
			? req.max_vertical_hz - RATE_OFFSET : req.max_vertical_hz;

		desc.flags = 4'h0;
		if (h_both)
			desc.flags = desc.flags | FLAG_H_BOTH;
		else if (req.max_horizontal_khz > RATE_OFFSET)
			desc.flags = desc.flags | FLAG_H_MAX;
		if (v_both)
			desc.flags = desc.flags | FLAG_V_BOTH;
		else if (req.max_vertical_hz > RATE_OFFSET)
			desc.flags = desc.flags | FLAG_V_MAX;

		// first failing check wins
		if (!hmin_ok)
			desc.err = ERR_MIN_H;
		else if (!hmax_ok)
			desc.err = ERR_MAX_H;
		else if (!vmin_ok)
			desc.err = ERR_MIN_V;
		else if (!vmax_ok)
			desc.err = ERR_MAX_V;
		else if (!clk_ok)
			desc.err = ERR_CLK_RANGE;
		else if (!clk_mult)
			desc.err = ERR_CLK_MULT;
		else
			desc.err = ERR_NONE;

		desc.vmin    = vmin_o[7:0];
		desc.vmax    = vmax_o[7:0];
		desc.hmin    = hmin_o[7:0];
		desc.hmax    = hmax_o[7:0];
		desc.clk_div = quot[7:0];
		desc.tsup    = req.timing_support;
	end

endmodule

// ===== design/rld_serial.sv =====
// Holds one encoded descriptor and sends it out a byte per cycle.
module rld_serial
	import rld_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  desc_t desc,
	output logic  free,
	output logic  result_stb,
	output res_t  result
);

	desc_t      desc_s2;
	logic       active_q;
	logic [4:0] cnt_q;
	logic       final_c;
	logic [7:0] sel_byte;
	logic       stb_s3;
	res_t       res_s3;

	assign final_c = active_q && ((desc_s2.err != ERR_NONE) || (cnt_q == IDX_LAST));
	assign free    = !active_q || final_c;

	always_comb begin
		case (cnt_q)
			IDX_TAG:   sel_byte = RANGE_TAG;
			IDX_FLAGS: sel_byte = {4'h0, desc_s2.flags};
			IDX_VMIN:  sel_byte = desc_s2.vmin;
			IDX_VMAX:  sel_byte = desc_s2.vmax;
			IDX_HMIN:  sel_byte = desc_s2.hmin;
			IDX_HMAX:  sel_byte = desc_s2.hmax;
			IDX_CLK:   sel_byte = desc_s2.clk_div;
			IDX_TSUP:  sel_byte = desc_s2.tsup;
			IDX_LF:    sel_byte = PAD_LF;
			default:   sel_byte = (cnt_q > IDX_LF) ? PAD_SPACE : 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= 5'd0;
			stb_s3   <= 1'b0;
		end else begin
			stb_s3 <= active_q;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= 5'd0;
			end else if (final_c) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_s2 <= desc;
		res_s3.byte_value <= (desc_s2.err != ERR_NONE) ? 8'h00 : sel_byte;
		res_s3.byte_index <= (desc_s2.err != ERR_NONE) ? 5'd0 : cnt_q;
		res_s3.last       <= final_c;
		res_s3.error_code <= desc_s2.err;
	end

	assign result_stb = stb_s3;
	assign result     = res_s3;

endmodule

// ===== design/range_limits_descriptor_encoder.sv =====
// Display range limits descriptor encoder: a request in, 18 descriptor bytes or one error out.
//
// A request is taken when start is high and busy is low. A valid request gives
// 18 results, byte_index 0..17, back to back with last on byte 17;
// a request that fails a check gives a single result with the error code,
// byte 0 and last set. A taken request passes through the input register, the
// descriptor register and the result register before its first result is on the ports.
// Results cannot be held off, so the byte serializer sets the pace: a valid request
// is loaded only as the last byte of the previous one is sent (failing requests go one
// per cycle). One request waits in the input register while the previous descriptor is being sent.
module range_limits_descriptor_encoder
	import rld_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic result_stb,
	output res_t result
);

	logic  valid_s1;
	req_t  req_s1;
	desc_t desc;
	logic  free;
	logic  load;
	logic  accept;

	assign load   = valid_s1 && free;
	assign busy   = valid_s1 && !free;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= request;
	end

	rld_encode u_encode (
		.req  (req_s1),
		.desc (desc)
	);

	rld_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.desc       (desc),
		.free       (free),
		.result_stb (result_stb),
		.result     (result)
	);

	// an error result is a lone zero byte at index 0
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && (result.error_code != ERR_NONE)
		|-> result.last && (result.byte_index == 5'd0) && (result.byte_value == 8'h00))
		else $error("error result malformed");

	// descriptor bytes come back to back with rising index
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && !result.last
		|=> result_stb && (result.byte_index == $past(result.byte_index) + 5'd1))
		else $error("descriptor run broken");

	// last only on the final descriptor byte or an error
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb && result.last && (result.error_code == ERR_NONE)
		|-> (result.byte_index == IDX_LAST))
		else $error("last on wrong byte");

	// a taken request is held until the serializer picks it up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid_s1)
		else $error("request lost");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the range limits descriptor encoder: directed and random requests, predicted bytes, checks.
`timescale 1ns / 1ps

module tb_top;
	import rld_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_COUNT = 300;
	localparam int DESC_LEN     = 18;

	// Expected descriptor bytes (or error results), oldest first.
	class descriptor_scoreboard;
		res_t pending_bytes[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void queue_result(res_t b);
			pending_bytes = {pending_bytes, b};
		endfunction

		// Work out what an accepted request must produce.
		function void note_request(req_t r);
			logic [9:0]  vmin;
			logic [9:0]  vmax;
			logic [9:0]  hmin;
			logic [9:0]  hmax;
			logic [11:0] pclk;
			logic [2:0]  err;
			logic [3:0]  flags;
			logic [7:0]  desc [DESC_LEN];
			res_t        b;
			vmin = r.min_vertical_hz;
			vmax = r.max_vertical_hz;
			hmin = r.min_horizontal_khz;
			hmax = r.max_horizontal_khz;
			pclk = r.max_pixel_clock_mhz;
			err = ERR_NONE;
			if (hmin < 10'd1 || hmin > RATE_LIMIT)
				err = ERR_MIN_H;
			else if (hmax < 10'd1 || hmax > RATE_LIMIT)
				err = ERR_MAX_H;
			else if (vmin < 10'd1 || vmin > RATE_LIMIT)
				err = ERR_MIN_V;
			else if (vmax < 10'd1 || vmax > RATE_LIMIT)
				err = ERR_MAX_V;
			else if (pclk < CLOCK_LOW || pclk > CLOCK_LIMIT)
				err = ERR_CLK_RANGE;
			else if (pclk % 10 != 0)
				err = ERR_CLK_MULT;
			if (err != ERR_NONE) begin
				b = '{byte_value: 8'h00, byte_index: 5'd0, last: 1'b1, error_code: err};
				queue_result(b);
				return;
			end
			flags = 4'h0;
			if (hmin > RATE_OFFSET && hmax > RATE_OFFSET) begin
				flags = flags | FLAG_H_BOTH;
				hmin = hmin - RATE_OFFSET;
				hmax = hmax - RATE_OFFSET;
			end else if (hmax > RATE_OFFSET) begin
				flags = flags | FLAG_H_MAX;
				hmax = hmax - RATE_OFFSET;
			end
			if (vmin > RATE_OFFSET && vmax > RATE_OFFSET) begin
				flags = flags | FLAG_V_BOTH;
				vmin = vmin - RATE_OFFSET;
				vmax = vmax - RATE_OFFSET;
			end else if (vmax > RATE_OFFSET) begin
				flags = flags | FLAG_V_MAX;
				vmax = vmax - RATE_OFFSET;
			end
			// a minimum above 255 without an offset just loses bit 8
			desc[0]  = 8'h00;
			desc[1]  = 8'h00;
			desc[2]  = 8'h00;
			desc[3]  = RANGE_TAG;
			desc[4]  = {4'h0, flags};
			desc[5]  = vmin[7:0];
			desc[6]  = vmax[7:0];
			desc[7]  = hmin[7:0];
			desc[8]  = hmax[7:0];
			desc[9]  = 8'(pclk / 12'd10);
			desc[10] = r.timing_support;
			desc[11] = PAD_LF;
			for (int i = 12; i < DESC_LEN; i++)
				desc[i] = PAD_SPACE;
			for (int i = 0; i < DESC_LEN; i++) begin
				b = '{byte_value: desc[i], byte_index: 5'(i),
					last: (i == DESC_LEN - 1), error_code: ERR_NONE};
				queue_result(b);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $realtime, got);
				mismatches++;
				return;
			end
			want = pending_bytes.pop_front();
			if (got.byte_value !== want.byte_value) begin
				$display("%0t: byte_value expected %02h got %02h", $realtime,
					want.byte_value, got.byte_value);
				mismatches++;
			end
			if (got.byte_index !== want.byte_index) begin
				$display("%0t: byte_index expected %0d got %0d", $realtime,
					want.byte_index, got.byte_index);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b got %b", $realtime, want.last, got.last);
				mismatches++;
			end
			if (got.error_code !== want.error_code) begin
				$display("%0t: error_code expected %0d got %0d", $realtime,
					want.error_code, got.error_code);
				mismatches++;
			end
		endfunction

		function void report_leftovers();
			if (pending_bytes.size() != 0) begin
				$display("%0t: %0d results expected but never seen, next expected %h",
					$realtime, pending_bytes.size(), pending_bytes[0]);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic result_stb;
	res_t result;

	descriptor_scoreboard sb;
	int cycle_count = 0;
	int gap_max = 3;

	range_limits_descriptor_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.result_stb (result_stb),
		.result     (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_stb === 1'b1)
			sb.check_result(result);

	function automatic req_t mk(int vmin, int vmax, int hmin, int hmax, int pclk, int tsup);
		req_t r;
		r.min_vertical_hz     = 10'(vmin);
		r.max_vertical_hz     = 10'(vmax);
		r.min_horizontal_khz  = 10'(hmin);
		r.max_horizontal_khz  = 10'(hmax);
		r.max_pixel_clock_mhz = 12'(pclk);
		r.timing_support      = 8'(tsup);
		return r;
	endfunction

	// Legal rate, leaning on the offset boundaries.
	function automatic int pick_rate();
		int sel;
		sel = $urandom_range(0, 11);
		case (sel)
			0: return 1;
			1: return 255;
			2: return 256;
			3: return 510;
			default: return $urandom_range(1, 510);
		endcase
	endfunction

	// Hold off start for a random gap bounded by gap_max, then present the request until it is taken.
	task automatic send_request(req_t r);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(r);
	endtask

	initial begin
		req_t directed[$];
		req_t r;
		int kind;
		int field;
		sb = new();
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = {directed, mk(56, 76, 30, 83, 170, 8'h00)};
		directed = {directed, mk(1, 1, 1, 1, 10, 8'hFF)};
		directed = {directed, mk(510, 510, 510, 510, 2550, 8'hA5)};
		directed = {directed, mk(50, 400, 100, 300, 1000, 8'h5A)};   // max only offsets
		directed = {directed, mk(256, 255, 300, 200, 20, 8'h01)};    // min high, no offset
		directed = {directed, mk(255, 256, 256, 256, 2540, 8'h80)};  // boundaries
		directed = {directed, mk(256, 256, 255, 256, 1280, 8'h7F)};
		directed = {directed, mk(10, 20, 0, 20, 100, 8'h00)};        // min H low
		directed = {directed, mk(10, 20, 511, 20, 100, 8'h00)};      // min H high
		directed = {directed, mk(10, 20, 1023, 20, 100, 8'h00)};
		directed = {directed, mk(10, 20, 30, 0, 100, 8'h00)};        // max H
		directed = {directed, mk(10, 20, 30, 511, 100, 8'h00)};
		directed = {directed, mk(0, 20, 30, 40, 100, 8'h00)};        // min V
		directed = {directed, mk(1023, 20, 30, 40, 100, 8'h00)};
		directed = {directed, mk(10, 511, 30, 40, 100, 8'h00)};      // max V
		directed = {directed, mk(10, 0, 30, 40, 100, 8'h00)};
		directed = {directed, mk(10, 20, 30, 40, 0, 8'h00)};         // clock range
		directed = {directed, mk(10, 20, 30, 40, 9, 8'h00)};
		directed = {directed, mk(10, 20, 30, 40, 2560, 8'h00)};
		directed = {directed, mk(10, 20, 30, 40, 4095, 8'h00)};
		directed = {directed, mk(10, 20, 30, 40, 15, 8'h00)};        // not a multiple of ten
		directed = {directed, mk(10, 20, 30, 40, 2549, 8'h00)};
		directed = {directed, mk(0, 0, 0, 0, 0, 8'h00)};             // first failing check wins
		directed = {directed, mk(0, 20, 30, 0, 5, 8'h00)};
		foreach (directed[i])
			send_request(directed[i]);

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			// phases with no hold-off at all
			if (n % 40 == 0)
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
			kind = $urandom_range(0, 19);
			r = mk(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
				10 * $urandom_range(1, 255), $urandom_range(0, 255));
			if (kind < 3) begin
				r = req_t'(60'({$urandom(), $urandom()}));
			end else if (kind < 6) begin
				field = $urandom_range(0, 4);
				case (field)
					0: r.min_vertical_hz     = 10'($urandom_range(0, 1023));
					1: r.max_vertical_hz     = 10'($urandom_range(0, 1023));
					2: r.min_horizontal_khz  = 10'($urandom_range(0, 1023));
					3: r.max_horizontal_khz  = 10'($urandom_range(0, 1023));
					default: r.max_pixel_clock_mhz = 12'($urandom_range(0, 4095));
				endcase
			end
			send_request(r);
		end
		start <= 1'b0;

		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		sb.report_leftovers();
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
